FILE: src/mtxmul_pkg.sv
// ----------------------------------------------------------------------------
// mtxmul_pkg
// Shared widths and parameter defaults for the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mtxmul_pkg;

  // default matrix dimension and fraction bits
  localparam int DIM_DEF       = 4;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths of the ports
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 4;
  localparam int COORD_W = 2;
  localparam int PROD_W  = 2 * DATA_W;

endpackage

`default_nettype wire

FILE: src/mtxmul_ram.sv
// ----------------------------------------------------------------------------
// mtxmul_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mtxmul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/matrix_multiply_4x4_unit.sv
// Timing: after a start beat is accepted, each product element is issued
// over the inner index, then passes the ram read, multiply, accumulate and
// output registers; the next element is issued only once it is loaded. One
// shared multiplier reads one left and one right element per cycle.
// Throughput: one element load per cycle while idle; none while a product runs.
// Reset: synchronous; both matrices read as zero until written, no clear pass.
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_unit
// Loads two DIM x DIM Q16.16 matrices element by element and streams their
// product in row-major order, rounded to nearest and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_4x4_unit
  import mtxmul_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // element load channel
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      func,
  input  wire logic [INDEX_W-1:0]        index,
  input  wire logic signed [DATA_W-1:0]  value,
  input  wire logic                      start_req,
  // product channel
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [COORD_W-1:0]             row,
  output logic [COORD_W-1:0]             column,
  output logic signed [DATA_W-1:0]       product,
  output logic                           overflow,
  output logic                           final_res
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(DIM);
  localparam int ACC_W = PROD_W + $clog2(DIM);
  localparam int RND_W = ACC_W + 1;
  localparam int HSH   = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
  localparam logic signed [RND_W-1:0] HALF =
    (FRAC_BITS > 0) ? (RND_W'(1) << HSH) : '0;
  localparam logic [CW-1:0] LAST = CW'(DIM - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] r, c, k;

  // per-entry valid bits: an unwritten entry reads as zero
  logic [CELLS-1:0] lvld, rvld;

  logic              wr_ok, in_fire, load;
  logic              l_we, r_we;
  logic [AW-1:0]     waddr, l_raddr, r_raddr;
  logic [DATA_W-1:0] l_q, r_q;
  logic              l_ok, r_ok;

  logic              iss_vld, iss_first, iss_last;
  logic              rd_vld, rd_first, rd_last;
  logic              mul_vld, mul_first, mul_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic              acc_rdy;

  logic signed [DATA_W-1:0] l_op, r_op;
  logic signed [RND_W-1:0]  rnd, shf;
  logic [RND_W-DATA_W:0]    hi_bits;
  logic                     ovf;
  logic [DATA_W-1:0]        sat;

  // input handshake and store writes
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign wr_ok    = (32'(index) < 32'(CELLS));
  assign waddr    = AW'(index);
  assign l_we     = in_fire && wr_ok && !func;
  assign r_we     = in_fire && wr_ok && func;

  // read addresses for left[r][k] and right[k][c]
  assign l_raddr  = AW'(AW'(r) * AW'(DIM) + AW'(k));
  assign r_raddr  = AW'(AW'(k) * AW'(DIM) + AW'(c));

  assign iss_vld   = (state == S_ISSUE);
  assign iss_first = (k == '0);
  assign iss_last  = (k == LAST);

  mtxmul_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_left (
    .clk   (clk),
    .we    (l_we),
    .waddr (waddr),
    .wdata (value),
    .raddr (l_raddr),
    .rdata (l_q)
  );

  mtxmul_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_right (
    .clk   (clk),
    .we    (r_we),
    .waddr (waddr),
    .wdata (value),
    .raddr (r_raddr),
    .rdata (r_q)
  );

  // valid bits, looked up alongside the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      lvld <= '0;
      rvld <= '0;
    end else begin
      if (l_we) lvld[waddr] <= 1'b1;
      if (r_we) rvld[waddr] <= 1'b1;
    end
    l_ok <= lvld[l_raddr];
    r_ok <= rvld[r_raddr];
  end

  assign l_op = l_ok ? $signed(l_q) : '0;
  assign r_op = r_ok ? $signed(r_q) : '0;

  // read, multiply and accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
      acc_rdy <= 1'b0;
    end else begin
      rd_vld  <= iss_vld;
      mul_vld <= rd_vld;
      if (mul_vld && mul_last) begin
        acc_rdy <= 1'b1;
      end else if (load) begin
        acc_rdy <= 1'b0;
      end
    end
    rd_first  <= iss_first;
    rd_last   <= iss_last;
    mul_first <= rd_first;
    mul_last  <= rd_last;
    prod      <= PROD_W'(l_op) * PROD_W'(r_op);
    if (mul_vld) begin
      acc <= mul_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // round to nearest and saturate
  always_comb begin
    rnd     = RND_W'(acc) + HALF;
    shf     = rnd >>> FRAC_BITS;
    hi_bits = shf[RND_W-1:DATA_W-1];
    ovf     = !((&hi_bits) || (~|hi_bits));
    if (ovf) begin
      sat = shf[RND_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat = shf[DATA_W-1:0];
    end
  end

  assign load = (state == S_WAIT) && acc_rdy && (!out_valid || out_ready);

  // sequencer over product elements and inner index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          r <= '0;
          c <= '0;
          k <= '0;
          if (in_fire && start_req) state <= S_ISSUE;
        end
        S_ISSUE: begin
          if (iss_last) begin
            k     <= '0;
            state <= S_WAIT;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_WAIT: begin
          if (load) begin
            state <= S_ISSUE;
            if (c == LAST) begin
              c <= '0;
              if (r == LAST) begin
                r     <= '0;
                state <= S_IDLE;
              end else begin
                r <= r + 1'b1;
              end
            end else begin
              c <= c + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      row       <= COORD_W'(r);
      column    <= COORD_W'(c);
      product   <= $signed(sat);
      overflow  <= ovf;
      final_res <= (r == LAST) && (c == LAST);
    end
  end

`ifndef SYNTHESIS
  // no new product may land on a finished sum not yet taken
  a_no_acc_clobber: assert property (@(posedge clk) disable iff (rst)
    !(acc_rdy && mul_vld))
    else $error("product arrived while a finished sum was pending");

  // the pipeline is empty whenever a load beat is taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (!rd_vld && !mul_vld && !acc_rdy))
    else $error("load beat accepted with work in flight");

  // every ram read turns into a product the next cycle
  a_rd_to_mul: assert property (@(posedge clk) disable iff (rst)
    rd_vld |=> mul_vld)
    else $error("read beat lost before multiply");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix_multiply_4x4_unit. Element loads go in
// through a queue-fed driver, and every start beat queues the 16 elements
// of the predicted Q16.16 product. A monitor checks each product beat field
// by field against the oldest pending element. Random idles, one long
// receiver hold-off and one full drain pause exercise the handshakes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtxmul_pkg::*;

  localparam int DIM         = DIM_DEF;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int CELLS       = DIM * DIM;
  localparam int ACC_W       = 72;
  localparam int HALF_PERIOD = 6;
  localparam int RAND_LOADS  = 300;
  // a no-beat stretch this long means the unit is hung; the worst legal one is
  // the receiver hold-off plus a few element times
  localparam int HOLD_LEN    = 400;
  localparam int HOLD_AT     = 60;
  localparam int STALL_LIMIT = 10 * HOLD_LEN;
  localparam int TAIL        = 4 * (DIM + 4);
  localparam int MAX_REPORTS = 200;

  localparam logic signed [ACC_W-1:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -72'sd2147483648;

  localparam bit SEL_LEFT  = 1'b0;
  localparam bit SEL_RIGHT = 1'b1;

  // kinds of element values drawn by the random part
  typedef enum int {VAL_FULL, VAL_SMALL, VAL_CORNER, VAL_BIG} val_kind_t;

  typedef struct packed {
    logic               func;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  value;
    logic               start;
    logic               drain;
  } load_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [DATA_W-1:0]  product;
    logic               overflow;
    logic               final_res;
  } elem_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic                      func      = 1'b0;
  logic [INDEX_W-1:0]        index     = '0;
  logic signed [DATA_W-1:0]  value     = '0;
  logic                      start_req = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [COORD_W-1:0]        row;
  logic [COORD_W-1:0]        column;
  logic signed [DATA_W-1:0]  product;
  logic                      overflow;
  logic                      final_res;

  load_t pending_loads[$];
  elem_t due_elems[$];

  // shadow copies of the two matrices, zero after reset
  logic signed [DATA_W-1:0] left_mat  [CELLS];
  logic signed [DATA_W-1:0] right_mat [CELLS];

  int offered_cnt  = 0;
  int taken_cnt    = 0;
  int results_seen = 0;
  int errors       = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  matrix_multiply_4x4_unit #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .index     (index),
    .value     (value),
    .start_req (start_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row       (row),
    .column    (column),
    .product   (product),
    .overflow  (overflow),
    .final_res (final_res)
  );

  // clock
  initial begin
    forever #(HALF_PERIOD) clk = ~clk;
  end

  task automatic add_load(input logic f, input int idx, input logic [DATA_W-1:0] v,
                          input logic s, input logic d = 1'b0);
    load_t ld;
    ld.func  = f;
    ld.index = idx[INDEX_W-1:0];
    ld.value = v;
    ld.start = s;
    ld.drain = d;
    pending_loads.push_back(ld);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(val_kind_t kind);
    logic [DATA_W-1:0] v;
    case (kind)
      VAL_SMALL: begin
        // magnitudes up to about 16.0
        v = $urandom_range(0, 32'h000F_FFFF);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      VAL_CORNER: begin
        case ($urandom_range(0, 6))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          4: v = 32'h0001_0000;
          5: v = 32'h0000_8000;
          default: v = 32'h0000_0001;
        endcase
      end
      VAL_BIG: begin
        // near the top of the range, either sign
        v = $urandom() | 32'h3000_0000;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // full product of the shadow matrices, rounded and saturated like the unit
  task automatic push_matrix_product();
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    elem_t e;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
          a   = left_mat[r*DIM + k];
          b   = right_mat[k*DIM + c];
          acc = acc + a * b;
        end
        // round to nearest, ties toward plus infinity
        if (FRAC > 0) acc = (acc + (72'sd1 <<< (FRAC - 1))) >>> FRAC;
        e.overflow = 1'b0;
        if (acc > SAT_HI) begin
          e.product  = 32'h7FFF_FFFF;
          e.overflow = 1'b1;
        end else if (acc < SAT_LO) begin
          e.product  = 32'h8000_0000;
          e.overflow = 1'b1;
        end else begin
          e.product = acc[DATA_W-1:0];
        end
        e.row       = r[COORD_W-1:0];
        e.column    = c[COORD_W-1:0];
        e.final_res = (r == DIM - 1) && (c == DIM - 1);
        due_elems.push_back(e);
      end
    end
  endtask

  function automatic void check_field(string name, elem_t want, logic [DATA_W-1:0] exp_v,
                                      logic [DATA_W-1:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: element (%0d,%0d) %s mismatch, expected %h, actual %h",
                 $time, want.row, want.column, name, exp_v, got_v);
    end
  endfunction

  // load beats: update the shadow matrices and predict on start
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      taken_cnt <= taken_cnt + 1;
      if (index < CELLS) begin
        if (func == SEL_RIGHT) right_mat[index] = value;
        else                   left_mat[index]  = value;
      end
      if (start_req) push_matrix_product();
    end
  end

  // load driver, fed from the pending queue
  always @(negedge clk) begin : load_driver
    load_t nxt;
    bit    sender_quiet;
    sender_quiet = (taken_cnt >= 140) && (taken_cnt < 230);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (taken_cnt == offered_cnt) begin
      // previous beat is gone; offer the next one unless idling or draining
      if (pending_loads.size() != 0
          && !(pending_loads[0].drain && due_elems.size() != 0)
          && (sender_quiet || $urandom_range(0, 99) >= 25)) begin
        nxt = pending_loads.pop_front();
        func      <= nxt.func;
        index     <= nxt.index;
        value     <= nxt.value;
        start_req <= nxt.start;
        in_valid  <= 1'b1;
        offered_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off so the unit backs up
  always @(negedge clk) begin : product_sink
    bit receiver_quiet;
    receiver_quiet = (results_seen >= 200) && (results_seen < 330);
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_ready <= receiver_quiet || ($urandom_range(0, 99) >= 25);
    end
  end

  // product beats against the oldest pending element
  always @(posedge clk) begin : product_monitor
    elem_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (due_elems.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected product beat, expected none, actual (%0d,%0d) %h",
                   $time, row, column, product);
      end else begin
        want = due_elems.pop_front();
        check_field("row",       want, DATA_W'(want.row),       DATA_W'(row));
        check_field("column",    want, DATA_W'(want.column),    DATA_W'(column));
        check_field("product",   want, want.product,            product);
        check_field("overflow",  want, DATA_W'(want.overflow),  DATA_W'(overflow));
        check_field("final_res", want, DATA_W'(want.final_res), DATA_W'(final_res));
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int        burst;
    int        made;
    val_kind_t kind;
    logic      f;

    for (int i = 0; i < CELLS; i++) begin
      left_mat[i]  = '0;
      right_mat[i] = '0;
    end

    // start on freshly cleared matrices
    add_load(SEL_LEFT, 0, 32'h0000_0000, 1'b1);
    // positive rounding tie goes up
    add_load(SEL_LEFT, 0, 32'h0000_0001, 1'b0);
    add_load(SEL_RIGHT, 0, 32'h0000_8000, 1'b1);
    // negative rounding tie goes toward plus infinity
    add_load(SEL_LEFT, 0, 32'hFFFF_FFFF, 1'b1);
    // positive saturation
    add_load(SEL_LEFT, 0, 32'h8000_0000, 1'b0);
    add_load(SEL_RIGHT, 0, 32'h8000_0000, 1'b1);
    // negative saturation
    add_load(SEL_RIGHT, 0, 32'h7FFF_FFFF, 1'b1);
    // full-scale row times full-scale column
    add_load(SEL_LEFT, 1, 32'h7FFF_FFFF, 1'b0);
    add_load(SEL_LEFT, 2, 32'h7FFF_FFFF, 1'b0);
    add_load(SEL_LEFT, 3, 32'h7FFF_FFFF, 1'b0);
    add_load(SEL_RIGHT, 4, 32'h7FFF_FFFF, 1'b0);
    add_load(SEL_RIGHT, 8, 32'h7FFF_FFFF, 1'b0);
    add_load(SEL_RIGHT, 12, 32'h7FFF_FFFF, 1'b1);
    // last index on both sides
    add_load(SEL_LEFT, 15, 32'hFFFF_FFFF, 1'b0);
    add_load(SEL_RIGHT, 15, 32'h8000_0000, 1'b1);
    // plain fixed-point values on the diagonal
    add_load(SEL_LEFT, 5, 32'h0001_0000, 1'b0);
    add_load(SEL_RIGHT, 5, 32'h0001_8000, 1'b0);
    add_load(SEL_LEFT, 10, 32'hFFFE_4000, 1'b0);
    add_load(SEL_RIGHT, 10, 32'h0002_0000, 1'b1);

    // random part: full reloads and short bursts, each mostly ending in a start
    made = 0;
    while (made < RAND_LOADS) begin
      kind = val_kind_t'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 2 * CELLS; i++) begin
          add_load(i >= CELLS, i % CELLS, pick_value(kind), i == 2 * CELLS - 1,
                   made == 0 && i == 0);
        end
        made += 2 * CELLS;
      end else begin
        burst = $urandom_range(1, 10);
        for (int i = 0; i < burst; i++) begin
          f = $urandom_range(0, 1);
          add_load(f, $urandom_range(0, CELLS - 1), pick_value(val_kind_t'($urandom_range(0, 3))),
                   (i == burst - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0),
                   made == 0 && i == 0);
        end
        made += burst;
      end
    end

    // reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_loads.size() != 0 || in_valid || due_elems.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
